// ===== rtl/core/dwc1d_pkg.sv =====
package dwc1d_pkg;

   localparam int SAMPLE_WIDTH       = 16;
   localparam int TAP_WIDTH          = 16;
   localparam int BIAS_WIDTH         = 16;
   localparam int TAP_COUNT          = 5;
   localparam int PAD                = 2;
   localparam int DELAY_DEPTH        = 4;
   localparam int IDX_WIDTH          = 2;
   localparam int COEF_FRAC_BITS_DEF = 14;
   localparam int CSR_ADDR_WIDTH     = 5;
   localparam int CSR_DATA_WIDTH     = 32;

   typedef logic signed [SAMPLE_WIDTH-1:0] sample_type;
   typedef logic signed [TAP_WIDTH-1:0]    tap_type;
   typedef logic signed [BIAS_WIDTH-1:0]   bias_type;

   typedef enum logic [2:0] {
      REG_TAP_ZERO    = 3'd0,
      REG_TAP_ONE     = 3'd1,
      REG_TAP_TWO     = 3'd2,
      REG_TAP_THREE   = 3'd3,
      REG_TAP_FOUR    = 3'd4,
      REG_BIAS_VALUE  = 3'd5,
      REG_RELU_ENABLE = 3'd6
   } reg_index_type;

   typedef struct packed {
      sample_type sample;
      logic       is_last;
   } req_payload_type;

   typedef struct packed {
      sample_type result;
      logic       result_last;
   } rsp_payload_type;

   // Entry 0 of the taps weights the oldest sample of the window.
   typedef struct packed {
      tap_type [TAP_COUNT-1:0] taps;
      bias_type                bias;
      logic                    relu_enable;
   } cfg_type;

   // Entry 0 of the samples is the oldest sample of the window.
   typedef struct packed {
      sample_type [TAP_COUNT-1:0] samples;
      logic                       last;
   } window_type;

endpackage

// ===== rtl/core/dwc1d_csr.sv =====
module dwc1d_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [dwc1d_pkg::CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [dwc1d_pkg::CSR_DATA_WIDTH-1:0] pwdata,
   output logic [dwc1d_pkg::CSR_DATA_WIDTH-1:0] prdata,
   output logic                                 pready,
   output dwc1d_pkg::cfg_type                   cfg
);
   import dwc1d_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type addr_index;
   logic          wr_en;

   assign addr_index = reg_index_type'(paddr[CSR_ADDR_WIDTH-1:2]);
   assign wr_en      = psel && penable && pwrite;
   assign pready     = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (addr_index)
            REG_TAP_ZERO:    cfg_in.taps[0]     = tap_type'(pwdata[TAP_WIDTH-1:0]);
            REG_TAP_ONE:     cfg_in.taps[1]     = tap_type'(pwdata[TAP_WIDTH-1:0]);
            REG_TAP_TWO:     cfg_in.taps[2]     = tap_type'(pwdata[TAP_WIDTH-1:0]);
            REG_TAP_THREE:   cfg_in.taps[3]     = tap_type'(pwdata[TAP_WIDTH-1:0]);
            REG_TAP_FOUR:    cfg_in.taps[4]     = tap_type'(pwdata[TAP_WIDTH-1:0]);
            REG_BIAS_VALUE:  cfg_in.bias        = bias_type'(pwdata[BIAS_WIDTH-1:0]);
            REG_RELU_ENABLE: cfg_in.relu_enable = pwdata[0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (addr_index)
         REG_TAP_ZERO:    prdata = CSR_DATA_WIDTH'(unsigned'(cfg_ff.taps[0]));
         REG_TAP_ONE:     prdata = CSR_DATA_WIDTH'(unsigned'(cfg_ff.taps[1]));
         REG_TAP_TWO:     prdata = CSR_DATA_WIDTH'(unsigned'(cfg_ff.taps[2]));
         REG_TAP_THREE:   prdata = CSR_DATA_WIDTH'(unsigned'(cfg_ff.taps[3]));
         REG_TAP_FOUR:    prdata = CSR_DATA_WIDTH'(unsigned'(cfg_ff.taps[4]));
         REG_BIAS_VALUE:  prdata = CSR_DATA_WIDTH'(unsigned'(cfg_ff.bias));
         REG_RELU_ENABLE: prdata = CSR_DATA_WIDTH'(cfg_ff.relu_enable);
         default:         prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== rtl/core/dwc1d_window.sv =====
module dwc1d_window (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  dwc1d_pkg::req_payload_type req_payload,
   output logic                       win_valid,
   input  logic                       win_ready,
   output dwc1d_pkg::window_type      window
);
   import dwc1d_pkg::*;

   localparam logic [IDX_WIDTH-1:0] IDX_LAST = IDX_WIDTH'(PAD);
   localparam logic [2:0]           POS_END  = 3'(TAP_COUNT);

   // Entry 0 of the delay line is the newest sample.
   sample_type           dl_ff       [DELAY_DEPTH];
   sample_type           dl_in       [DELAY_DEPTH];
   logic [IDX_WIDTH-1:0] seen_ff;
   logic [IDX_WIDTH-1:0] seen_in;
   logic                 job_v_ff;
   logic                 job_v_in;
   logic                 job_last_ff;
   logic                 job_last_in;
   logic [IDX_WIDTH-1:0] job_idx_ff;
   logic [IDX_WIDTH-1:0] job_idx_in;
   sample_type           job_buf_ff  [TAP_COUNT];
   sample_type           job_buf_in  [TAP_COUNT];
   logic                 req_fire;
   logic                 emit;
   logic                 finish;
   logic [2:0]           pos         [TAP_COUNT];

   // A job is one accepted item that owes results; a last item owes one result per
   // window start, the others at most one.
   assign emit      = job_v_ff && win_ready;
   assign finish    = emit && (!job_last_ff || job_idx_ff == IDX_LAST);
   assign req_stall = job_v_ff && !finish;
   assign req_fire  = req_valid && !req_stall;
   assign win_valid = job_v_ff;

   // Window positions beyond the newest sample are the trailing padding zeros.
   always_comb begin
      for (int k = 0; k < TAP_COUNT; k++) begin
         pos[k] = 3'(job_idx_ff) + 3'(k);
         if (pos[k] < POS_END) begin
            window.samples[k] = job_buf_ff[pos[k]];
         end else begin
            window.samples[k] = '0;
         end
      end
      window.last = job_last_ff && (job_idx_ff == IDX_LAST);
   end

   always_comb begin
      dl_in       = dl_ff;
      seen_in     = seen_ff;
      job_v_in    = job_v_ff;
      job_last_in = job_last_ff;
      job_idx_in  = job_idx_ff;
      job_buf_in  = job_buf_ff;
      if (emit && !finish) begin
         job_idx_in = job_idx_ff + 1'b1;
      end
      if (finish) begin
         job_v_in = 1'b0;
      end
      if (req_fire) begin
         for (int k = 0; k < DELAY_DEPTH; k++) begin
            job_buf_in[k] = dl_ff[DELAY_DEPTH-1-k];
         end
         job_buf_in[TAP_COUNT-1] = req_payload.sample;
         if (req_payload.is_last) begin
            job_v_in    = 1'b1;
            job_last_in = 1'b1;
            job_idx_in  = IDX_LAST - seen_ff;
            for (int k = 0; k < DELAY_DEPTH; k++) begin
               dl_in[k] = '0;
            end
            seen_in = '0;
         end else begin
            if (seen_ff == IDX_LAST) begin
               job_v_in    = 1'b1;
               job_last_in = 1'b0;
               job_idx_in  = '0;
            end
            for (int k = DELAY_DEPTH-1; k > 0; k--) begin
               dl_in[k] = dl_ff[k-1];
            end
            dl_in[0] = req_payload.sample;
            if (seen_ff != IDX_LAST) begin
               seen_in = seen_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DELAY_DEPTH; k++) begin
            dl_ff[k] <= '0;
         end
         seen_ff     <= '0;
         job_v_ff    <= 1'b0;
         job_last_ff <= 1'b0;
         job_idx_ff  <= '0;
      end else begin
         dl_ff       <= dl_in;
         seen_ff     <= seen_in;
         job_v_ff    <= job_v_in;
         job_last_ff <= job_last_in;
         job_idx_ff  <= job_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      job_buf_ff <= job_buf_in;
   end

endmodule

// ===== rtl/core/dwc1d_mac.sv =====
module dwc1d_mac #(
   parameter int COEF_FRAC_BITS = dwc1d_pkg::COEF_FRAC_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  dwc1d_pkg::cfg_type         cfg,
   input  logic                       win_valid,
   output logic                       win_ready,
   input  dwc1d_pkg::window_type      window,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output dwc1d_pkg::rsp_payload_type rsp_payload
);
   import dwc1d_pkg::*;

   localparam int PROD_W = SAMPLE_WIDTH + TAP_WIDTH;
   localparam int OFF_W  = BIAS_WIDTH + COEF_FRAC_BITS;
   localparam int ACC_W  = ((PROD_W > OFF_W) ? PROD_W : OFF_W) + 4;
   localparam int QW     = ACC_W - COEF_FRAC_BITS;
   localparam logic signed [QW-1:0] Q_MAX = QW'((1 << (SAMPLE_WIDTH - 1)) - 1);
   localparam logic signed [QW-1:0] Q_MIN = -Q_MAX - QW'(1);

   logic signed [PROD_W-1:0] prod_ff [TAP_COUNT];
   logic signed [PROD_W-1:0] prod_in [TAP_COUNT];
   logic                     p_v_ff;
   logic                     p_last_ff;
   logic                     p_ready;
   logic                     rsp_ready;
   logic                     rsp_v_ff;
   rsp_payload_type          rsp_ff;
   rsp_payload_type          rsp_in;
   logic signed [OFF_W-1:0]  offset;
   logic signed [ACC_W-1:0]  acc;
   logic signed [QW-1:0]     q;
   logic signed [QW-1:0]     sat;
   sample_type               res;

   assign rsp_ready   = !rsp_v_ff || !rsp_stall;
   assign p_ready     = !p_v_ff || rsp_ready;
   assign win_ready   = p_ready;
   assign rsp_valid   = rsp_v_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      for (int k = 0; k < TAP_COUNT; k++) begin
         prod_in[k] = $signed(window.samples[k]) * $signed(cfg.taps[k]);
      end
   end

   // The bias scaled up plus the rounding half is a plain bit pattern, no adder needed.
   assign offset = {cfg.bias, 1'b1, {(COEF_FRAC_BITS-1){1'b0}}};

   always_comb begin
      acc = ACC_W'(offset);
      for (int k = 0; k < TAP_COUNT; k++) begin
         acc = acc + ACC_W'(prod_ff[k]);
      end
      // Dropping the fraction bits of a two's complement value rounds towards minus infinity.
      q = acc[ACC_W-1:COEF_FRAC_BITS];
      if (q > Q_MAX) begin
         sat = Q_MAX;
      end else if (q < Q_MIN) begin
         sat = Q_MIN;
      end else begin
         sat = q;
      end
      res = sample_type'(sat);
      if (cfg.relu_enable && res[SAMPLE_WIDTH-1]) begin
         res = '0;
      end
      rsp_in.result      = res;
      rsp_in.result_last = p_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_v_ff   <= 1'b0;
         rsp_v_ff <= 1'b0;
      end else begin
         if (p_ready) begin
            p_v_ff <= win_valid;
         end
         if (rsp_ready) begin
            rsp_v_ff <= p_v_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (p_ready) begin
         prod_ff   <= prod_in;
         p_last_ff <= window.last;
      end
      if (rsp_ready) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

// ===== rtl/core/depthwise_conv1d_k5_pad2_unit.sv =====
// Each window passes the job register, the product register and the result register in turn.
// Throughput: one item per cycle while the output does not stall; a last item flushes up to
// three results, one window a cycle from the job register, and stalls the input meanwhile.
// Reset is synchronous and active high: it clears the settings and control registers, empties
// the delay line and the sample count, and drops all valids. No clearing pass needed.
module depthwise_conv1d_k5_pad2_unit #(
   parameter int COEF_FRAC_BITS = dwc1d_pkg::COEF_FRAC_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  dwc1d_pkg::req_payload_type           req_payload,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output dwc1d_pkg::rsp_payload_type           rsp_payload,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [dwc1d_pkg::CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [dwc1d_pkg::CSR_DATA_WIDTH-1:0] pwdata,
   output logic [dwc1d_pkg::CSR_DATA_WIDTH-1:0] prdata,
   output logic                                 pready
);
   import dwc1d_pkg::*;

   cfg_type    cfg;
   logic       win_valid;
   logic       win_ready;
   window_type window;

   dwc1d_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   dwc1d_window u_window (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .win_valid   (win_valid),
      .win_ready   (win_ready),
      .window      (window)
   );

   dwc1d_mac #(
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_mac (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .win_valid   (win_valid),
      .win_ready   (win_ready),
      .window      (window),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== rtl/core/dwc1d_checker.sv =====
module dwc1d_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_stall,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input dwc1d_pkg::rsp_payload_type           rsp_payload,
   input logic                                 psel,
   input logic                                 penable,
   input logic                                 pwrite,
   input logic [dwc1d_pkg::CSR_ADDR_WIDTH-1:0] paddr,
   input logic [dwc1d_pkg::CSR_DATA_WIDTH-1:0] pwdata,
   input logic [dwc1d_pkg::CSR_DATA_WIDTH-1:0] prdata
);
   import dwc1d_pkg::*;

   // A stalled result item stays on the port unchanged.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("result item changed while stalled");

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   assert property (@(posedge clock) reset |=> !req_stall)
      else $error("input stalled after reset");

   // A tap written and read back at once returns the written value.
   assert property (@(posedge clock) disable iff (reset)
      (psel && penable && pwrite && paddr[CSR_ADDR_WIDTH-1:2] == REG_TAP_ZERO) |=>
      ((psel && penable && !pwrite && paddr[CSR_ADDR_WIDTH-1:2] == REG_TAP_ZERO) |->
       prdata[TAP_WIDTH-1:0] == $past(pwdata[TAP_WIDTH-1:0])))
      else $error("tap read back differs from the value written");

endmodule

bind depthwise_conv1d_k5_pad2_unit dwc1d_checker u_checker (.*);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
   import dwc1d_pkg::*;

   localparam int CSR_STRIDE      = 4;
   localparam int REG_UNUSED      = 7;
   localparam int DIRECTED_COUNT  = 25;
   localparam int PHASE_COUNT     = 6;
   localparam int PHASE_ITEMS     = 46;
   localparam int PRESSURE_PHASE  = 4;
   localparam int HOLD_CYCLES     = 200;
   localparam int SETTLE_CYCLES   = 8;
   localparam int DRAIN_LIMIT     = 20000;
   localparam longint SAT_HI      = (longint'(1) << (SAMPLE_WIDTH - 1)) - 1;
   localparam longint SAT_LO      = -SAT_HI - 1;

   localparam sample_type S_MAX     = 16'sh7fff;
   localparam sample_type S_MIN     = 16'sh8000;
   localparam tap_type    TAP_HI    = 16'sh7fff;
   localparam tap_type    TAP_LO    = 16'sh8000;
   localparam tap_type    UNITY_TAP = tap_type'(1 << COEF_FRAC_BITS_DEF);

   typedef enum int {
      PRESET_NONE,
      PRESET_POS_SAT,
      PRESET_NEG_RELU,
      PRESET_MIN_TAPS,
      PRESET_IDENTITY,
      PRESET_HALF
   } preset_type;

   typedef enum int {
      CFG_SMALL,
      CFG_FULL,
      CFG_EXTREME
   } cfg_style_type;

   typedef struct {
      preset_type preset;
      sample_type sample;
      logic       last;
      bit         known;
      sample_type known_val;
   } stim_row_type;

   // Rows marked known carry the value every result of that item must take.
   stim_row_type directed_rows [DIRECTED_COUNT] = '{
      '{PRESET_NONE,     S_MAX,        1'b0, 1'b1, 16'sd0},
      '{PRESET_NONE,     S_MIN,        1'b0, 1'b1, 16'sd0},
      '{PRESET_NONE,     16'sd1,       1'b1, 1'b1, 16'sd0},
      '{PRESET_NONE,     -16'sd1,      1'b1, 1'b1, 16'sd0},
      '{PRESET_POS_SAT,  S_MAX,        1'b1, 1'b1, S_MAX},
      '{PRESET_NONE,     S_MAX,        1'b0, 1'b1, S_MAX},
      '{PRESET_NONE,     S_MAX,        1'b1, 1'b1, S_MAX},
      '{PRESET_NONE,     S_MIN,        1'b0, 1'b1, S_MIN},
      '{PRESET_NONE,     S_MIN,        1'b0, 1'b1, S_MIN},
      '{PRESET_NONE,     S_MIN,        1'b0, 1'b1, S_MIN},
      '{PRESET_NONE,     S_MIN,        1'b1, 1'b1, S_MIN},
      '{PRESET_NEG_RELU, S_MIN,        1'b0, 1'b1, 16'sd0},
      '{PRESET_NONE,     S_MIN,        1'b0, 1'b1, 16'sd0},
      '{PRESET_NONE,     S_MAX,        1'b1, 1'b1, 16'sd0},
      '{PRESET_MIN_TAPS, S_MIN,        1'b1, 1'b1, S_MAX},
      '{PRESET_NONE,     S_MAX,        1'b1, 1'b1, S_MIN},
      '{PRESET_NONE,     16'sd0,       1'b1, 1'b1, S_MIN},
      '{PRESET_IDENTITY, 16'sd100,     1'b0, 1'b0, 16'sd0},
      '{PRESET_NONE,     -16'sd200,    1'b0, 1'b0, 16'sd0},
      '{PRESET_NONE,     16'sd300,     1'b0, 1'b0, 16'sd0},
      '{PRESET_NONE,     -16'sd400,    1'b0, 1'b0, 16'sd0},
      '{PRESET_NONE,     16'sd500,     1'b1, 1'b0, 16'sd0},
      '{PRESET_HALF,     16'sd1,       1'b1, 1'b0, 16'sd0},
      '{PRESET_NONE,     -16'sd1,      1'b1, 1'b0, 16'sd0},
      '{PRESET_NONE,     16'sd3,       1'b1, 1'b0, 16'sd0}
   };

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   req_payload_type           req_payload;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   rsp_payload_type           rsp_payload;
   logic                      psel;
   logic                      penable;
   logic                      pwrite;
   logic [CSR_ADDR_WIDTH-1:0] paddr;
   logic [CSR_DATA_WIDTH-1:0] pwdata;
   logic [CSR_DATA_WIDTH-1:0] prdata;
   logic                      pready;

   // Shadow of the filter: settings, delay line (entry 0 newest) and sample count.
   tap_type    coef [TAP_COUNT];
   bias_type   offset;
   logic       clamp_neg;
   sample_type history [DELAY_DEPTH];
   int         seen_in_seq;
   longint     span_buf [TAP_COUNT + PAD];

   rsp_payload_type pending_results [$];
   rsp_payload_type oldest;
   int              mismatches = 0;
   int              send_idle_pct = 0;
   int              recv_stall_pct = 0;
   bit              hold_request = 1'b0;
   logic            hold_on = 1'b0;

   depthwise_conv1d_k5_pad2_unit DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic void flag_error(input string msg);
      mismatches++;
      if (mismatches <= 10) $display("%0t: %s", $time, msg);
   endfunction

   function automatic void clear_filter_state();
      for (int k = 0; k < DELAY_DEPTH; k++) history[k] = '0;
      seen_in_seq = 0;
   endfunction

   // Biased, rounded (ties upward), saturated and optionally ReLU-clamped output for the window
   // that starts at span_buf[first].
   function automatic sample_type window_output(input int first);
      longint acc;
      acc = longint'(offset) * (longint'(1) << COEF_FRAC_BITS_DEF);
      for (int k = 0; k < TAP_COUNT; k++) acc += longint'(coef[k]) * span_buf[first + k];
      acc += longint'(1) << (COEF_FRAC_BITS_DEF - 1);
      acc = acc >>> COEF_FRAC_BITS_DEF;
      if (acc > SAT_HI) acc = SAT_HI;
      if (acc < SAT_LO) acc = SAT_LO;
      if (clamp_neg && acc < 0) acc = 0;
      return sample_type'(acc);
   endfunction

   task automatic predict_outputs(input req_payload_type it, input bit known,
                                  input sample_type known_val);
      rsp_payload_type r;
      int first;
      span_buf[0] = history[3];
      span_buf[1] = history[2];
      span_buf[2] = history[1];
      span_buf[3] = history[0];
      span_buf[4] = it.sample;
      span_buf[5] = 0;
      span_buf[6] = 0;
      if (!it.is_last) begin
         if (seen_in_seq >= PAD) begin
            r.result      = known ? known_val : window_output(0);
            r.result_last = 1'b0;
            pending_results.push_back(r);
         end
         for (int k = DELAY_DEPTH - 1; k > 0; k--) history[k] = history[k - 1];
         history[0] = it.sample;
         if (seen_in_seq < PAD) seen_in_seq++;
      end else begin
         // The last item flushes the tail windows, padded with zeros.
         first = PAD - seen_in_seq;
         for (int k = first; k <= PAD; k++) begin
            r.result      = known ? known_val : window_output(k);
            r.result_last = (k == PAD);
            pending_results.push_back(r);
         end
         clear_filter_state();
      end
   endtask

   // Leaves psel high so that writes can follow back to back.
   task automatic csr_write(input int idx, input logic [CSR_DATA_WIDTH-1:0] word);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_WIDTH'(idx * CSR_STRIDE);
      pwdata  <= word;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (idx < TAP_COUNT) coef[idx] = tap_type'(word[TAP_WIDTH-1:0]);
      else if (idx == REG_BIAS_VALUE) offset = bias_type'(word[BIAS_WIDTH-1:0]);
      else if (idx == REG_RELU_ENABLE) clamp_neg = word[0];
   endtask

   // Upper data bits are random, and the unused index gets a random word too.
   task automatic apply_settings(input cfg_type s);
      logic [CSR_DATA_WIDTH-1:0] word;
      for (int k = 0; k <= REG_UNUSED; k++) begin
         word = $urandom();
         if (k < TAP_COUNT) word[TAP_WIDTH-1:0] = s.taps[k];
         else if (k == REG_BIAS_VALUE) word[BIAS_WIDTH-1:0] = s.bias;
         else if (k == REG_RELU_ENABLE) word[0] = s.relu_enable;
         csr_write(k, word);
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   function automatic cfg_type preset_settings(input preset_type p);
      cfg_type s;
      s = '0;
      case (p)
         PRESET_POS_SAT: begin
            for (int k = 0; k < TAP_COUNT; k++) s.taps[k] = TAP_HI;
         end
         PRESET_NEG_RELU: begin
            for (int k = 0; k < TAP_COUNT; k++) s.taps[k] = TAP_HI;
            s.relu_enable = 1'b1;
         end
         PRESET_MIN_TAPS: begin
            for (int k = 0; k < TAP_COUNT; k++) s.taps[k] = TAP_LO;
            s.bias = S_MIN;
         end
         PRESET_IDENTITY: s.taps[PAD] = UNITY_TAP;
         PRESET_HALF:     s.taps[PAD] = UNITY_TAP >>> 1;
         default: ;
      endcase
      return s;
   endfunction

   function automatic tap_type extreme_tap();
      case ($urandom_range(0, 3))
         0:       return TAP_HI;
         1:       return TAP_LO;
         2:       return '0;
         default: return UNITY_TAP;
      endcase
   endfunction

   function automatic cfg_type random_settings(input cfg_style_type style);
      cfg_type s;
      s = '0;
      for (int k = 0; k < TAP_COUNT; k++) begin
         case (style)
            CFG_SMALL:   s.taps[k] = tap_type'(int'($urandom_range(0, 8192)) - 4096);
            CFG_FULL:    s.taps[k] = tap_type'($urandom());
            default:     s.taps[k] = extreme_tap();
         endcase
      end
      case (style)
         CFG_SMALL: s.bias = bias_type'(int'($urandom_range(0, 512)) - 256);
         CFG_FULL:  s.bias = bias_type'($urandom());
         default:   s.bias = $urandom_range(0, 1) ? S_MAX : S_MIN;
      endcase
      s.relu_enable = 1'($urandom_range(0, 1));
      return s;
   endfunction

   function automatic sample_type pick_sample();
      case ($urandom_range(0, 9))
         0:       return S_MAX;
         1:       return S_MIN;
         2:       return '0;
         3:       return sample_type'(int'($urandom_range(0, 32)) - 16);
         default: return sample_type'($urandom());
      endcase
   endfunction

   task automatic send_item(input sample_type s, input logic last, input bit known,
                            input sample_type known_val);
      req_payload_type it;
      it.sample  = s;
      it.is_last = last;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= it;
      do @(posedge clock); while (req_stall);
      predict_outputs(it, known, known_val);
   endtask

   // A sequence may end on an item that gives no result, so allow some settling.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   always @(posedge clock) begin
      rsp_stall <= hold_on || ($urandom_range(0, 99) < recv_stall_pct);
   end

   // The long hold-off lets the block fill up and push back on its input.
   initial begin
      wait (hold_request);
      @(posedge clock);
      hold_on <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_on <= 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            flag_error($sformatf("unexpected item: result %0d last %0b",
                                 rsp_payload.result, rsp_payload.result_last));
         end else begin
            oldest = pending_results.pop_front();
            if (rsp_payload.result !== oldest.result)
               flag_error($sformatf("result: expected %0d, got %0d",
                                    oldest.result, rsp_payload.result));
            if (rsp_payload.result_last !== oldest.result_last)
               flag_error($sformatf("result_last: expected %0b, got %0b",
                                    oldest.result_last, rsp_payload.result_last));
         end
      end
   end

   initial begin : stimulus
      int sent;
      int len;
      cfg_style_type style;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      psel        = 1'b0;
      penable     = 1'b0;
      pwrite      = 1'b0;
      paddr       = '0;
      pwdata      = '0;
      for (int k = 0; k < TAP_COUNT; k++) coef[k] = '0;
      offset    = '0;
      clamp_neg = 1'b0;
      clear_filter_state();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         if (directed_rows[i].preset != PRESET_NONE) begin
            wait_idle();
            apply_settings(preset_settings(directed_rows[i].preset));
         end
         send_item(directed_rows[i].sample, directed_rows[i].last, directed_rows[i].known,
                   directed_rows[i].known_val);
      end

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         wait_idle();
         case (phase)
            0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  style = CFG_SMALL;   end
            1:       begin send_idle_pct = 74; recv_stall_pct = 0;  style = CFG_FULL;    end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 74; style = CFG_EXTREME; end
            3:       begin send_idle_pct = 24; recv_stall_pct = 24; style = CFG_SMALL;   end
            4:       begin send_idle_pct = 0;  recv_stall_pct = 0;  style = CFG_FULL;    end
            default: begin send_idle_pct = 24; recv_stall_pct = 24; style = CFG_EXTREME; end
         endcase
         apply_settings(random_settings(style));
         if (phase == PRESSURE_PHASE) hold_request = 1'b1;
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 16);
            for (int j = 0; j < len; j++) begin
               send_item(pick_sample(), j == len - 1, 1'b0, '0);
               sent++;
            end
         end
      end

      req_valid <= 1'b0;
      for (int w = 0; w < DRAIN_LIMIT && pending_results.size() != 0; w++) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_results.size() != 0)
         flag_error($sformatf("%0d results never arrived", pending_results.size()));
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("TEST FAILED");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/dwc1d_pkg.sv
rtl/core/dwc1d_csr.sv
rtl/core/dwc1d_window.sv
rtl/core/dwc1d_mac.sv
rtl/core/depthwise_conv1d_k5_pad2_unit.sv
rtl/core/dwc1d_checker.sv
tb/tb.sv
